// ===== rtl/uyvy2bgra_pkg.sv =====
// Shared types and fixed coefficients for the UYVY to BGRA converter.
// No dependencies; used by every module under rtl/.
package uyvy2bgra_pkg;

  localparam int unsigned SUM_W = 20;

  localparam logic [7:0]         LUMA_OFS  = 8'd16;
  localparam logic [8:0]         K_Y       = 9'd298;
  localparam logic signed [10:0] K_CR_R    = 11'sd459;
  localparam logic signed [8:0]  K_CB_G    = -9'sd55;
  localparam logic signed [8:0]  K_CR_G    = -9'sd136;
  localparam logic signed [10:0] K_CB_B    = 11'sd541;
  localparam logic signed [SUM_W-1:0] ROUND_C = 20'sd128;
  localparam logic [7:0]         ALPHA_C   = 8'hFF;

  typedef struct packed {
    logic [7:0] cb_sample;
    logic [7:0] luma_even;
    logic [7:0] cr_sample;
    logic [7:0] luma_odd;
    logic       frame_end;
  } uyvy_in_t;

  typedef struct packed {
    logic [31:0] even_pixel;
    logic [31:0] odd_pixel;
    logic        frame_end_out;
  } bgra_out_t;

  typedef struct packed {
    logic signed [16:0] r_term;
    logic signed [15:0] g_term;
    logic signed [17:0] b_term;
  } chroma_terms_t;

endpackage

// ===== rtl/uyvy_to_bgra_color_converter.sv =====
// Top level of the UYVY to BGRA converter: beat handshakes, two pixel lanes,
// shared chroma stage and output register. Depends on uyvy2bgra_pkg,
// uyvy2bgra_chroma and uyvy2bgra_lane.
//
// Usage:
//   in_*  : one beat = one packed 4:2:2 pair (Cb, Y0, Cr, Y1) plus frame end.
//   out_* : one beat = two BGRA pixels sharing the pair's chroma, alpha 0xFF,
//           and the frame end flag copied through.
//   One output beat per input beat, in order.
// Timing:
//   An accepted beat passes the product register, then the output register,
//   before out_valid. Throughput is one beat per cycle while out_ready is high;
//   the two lanes and the constant-coefficient multipliers are fully pipelined.
// Reset:
//   rst_n low clears both stage valid flags; the pipe is empty afterwards
//   and in_ready is high.
// Stall:
//   When out_ready is low with out_valid high, the output register holds. An
//   empty product stage still takes one more beat, then in_ready drops until the output drains.
module uyvy_to_bgra_color_converter import uyvy2bgra_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  uyvy_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output bgra_out_t out_data
);

  logic          en1;
  logic          en2;
  logic          s1_valid_r;
  logic          s1_valid_nxt;
  logic          s1_fe_r;
  logic          out_valid_r;
  logic          out_valid_nxt;
  bgra_out_t     out_data_r;
  bgra_out_t     out_data_nxt;
  chroma_terms_t terms;
  logic [31:0]   even_px;
  logic [31:0]   odd_px;

  assign en2 = !out_valid_r || out_ready;
  assign en1 = !s1_valid_r || en2;
  assign in_ready = en1;

  uyvy2bgra_chroma u_chroma (
    .clk       (clk),
    .en        (en1),
    .cb_sample (in_data.cb_sample),
    .cr_sample (in_data.cr_sample),
    .terms     (terms)
  );

  uyvy2bgra_lane u_lane_even (
    .clk   (clk),
    .en    (en1),
    .luma  (in_data.luma_even),
    .terms (terms),
    .pixel (even_px)
  );

  uyvy2bgra_lane u_lane_odd (
    .clk   (clk),
    .en    (en1),
    .luma  (in_data.luma_odd),
    .terms (terms),
    .pixel (odd_px)
  );

  always_comb begin
    s1_valid_nxt = en1 ? in_valid : s1_valid_r;
    out_valid_nxt = en2 ? s1_valid_r : out_valid_r;
    out_data_nxt.even_pixel    = even_px;
    out_data_nxt.odd_pixel     = odd_px;
    out_data_nxt.frame_end_out = s1_fe_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_fe_r <= in_data.frame_end;
    end
    if (en2) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_alpha: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.even_pixel[31:24] == ALPHA_C &&
                     out_data_r.odd_pixel[31:24] == ALPHA_C))
    else $error("alpha byte not 0xFF");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_ready) |-> !in_ready)
    else $error("accepting while both stages full and stalled");

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> s1_valid_r)
    else $error("accepted beat lost in product stage");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && (!out_valid_r || out_ready)) |=> out_valid_r)
    else $error("product stage beat not moved to output");

endmodule

// ===== rtl/uyvy2bgra_chroma.sv =====
// Chroma product stage: removes the 128 offset and forms the color-difference
// terms shared by both pixel lanes. Depends on uyvy2bgra_pkg.
module uyvy2bgra_chroma import uyvy2bgra_pkg::*; (
  input  logic          clk,
  input  logic          en,
  input  logic [7:0]    cb_sample,
  input  logic [7:0]    cr_sample,
  output chroma_terms_t terms
);

  logic signed [7:0] cb_c;
  logic signed [7:0] cr_c;
  chroma_terms_t     terms_r;
  chroma_terms_t     terms_nxt;

  // x - 128 on a byte is a flip of the msb
  assign cb_c = $signed({~cb_sample[7], cb_sample[6:0]});
  assign cr_c = $signed({~cr_sample[7], cr_sample[6:0]});

  always_comb begin
    terms_nxt.r_term = 17'(K_CR_R * cr_c);
    terms_nxt.g_term = 16'(K_CB_G * cb_c) + 16'(K_CR_G * cr_c);
    terms_nxt.b_term = 18'(K_CB_B * cb_c);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      terms_r <= terms_nxt;
    end
  end

  assign terms = terms_r;

endmodule

// ===== rtl/uyvy2bgra_lane.sv =====
// One pixel lane: registered luma scaling, then channel sums, rounding shift,
// saturation and BGRA packing. Depends on uyvy2bgra_pkg.
module uyvy2bgra_lane import uyvy2bgra_pkg::*; (
  input  logic          clk,
  input  logic          en,
  input  logic [7:0]    luma,
  input  chroma_terms_t terms,
  output logic [31:0]   pixel
);

  logic [7:0]              y_ofs;
  logic [16:0]             luma_term_r;
  logic [16:0]             luma_term_nxt;
  logic signed [SUM_W-1:0] c_s;
  logic signed [SUM_W-1:0] r_sum;
  logic signed [SUM_W-1:0] g_sum;
  logic signed [SUM_W-1:0] b_sum;

  function automatic logic [7:0] sat8(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] s;
    s = v >>> 8;
    if (s[SUM_W-1]) begin
      sat8 = 8'd0;
    end else if (|s[SUM_W-2:8]) begin
      sat8 = 8'hFF;
    end else begin
      sat8 = s[7:0];
    end
  endfunction

  assign y_ofs         = (luma < LUMA_OFS) ? 8'd0 : luma - LUMA_OFS;
  assign luma_term_nxt = 17'(y_ofs * K_Y);

  always_ff @(posedge clk) begin
    if (en) begin
      luma_term_r <= luma_term_nxt;
    end
  end

  assign c_s   = $signed({3'b000, luma_term_r});
  assign r_sum = c_s + SUM_W'(terms.r_term) + ROUND_C;
  assign g_sum = c_s + SUM_W'(terms.g_term) + ROUND_C;
  assign b_sum = c_s + SUM_W'(terms.b_term) + ROUND_C;

  assign pixel = {ALPHA_C, sat8(r_sum), sat8(g_sum), sat8(b_sum)};

endmodule

// ===== verif/tb_uyvy_to_bgra_color_converter.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for uyvy_to_bgra_color_converter: directed and random pixel pairs,
// predicted BGRA pixels compared per beat. Depends on uyvy2bgra_pkg and the converter RTL.
module tb_uyvy_to_bgra_color_converter import uyvy2bgra_pkg::*;;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 6;
  localparam int IDLE_PERCENT   = 17;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  uyvy_in_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  bgra_out_t out_data;

  bgra_out_t expected_pixels[$];
  bgra_out_t want_beat;
  bit        idle_on = 1'b1;
  int        mismatch_count = 0;
  int        quiet_cycles = 0;

  uyvy_to_bgra_color_converter u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  function automatic logic [7:0] limit_to_byte(int value);
    if (value < 0) return 8'd0;
    if (value > 255) return 8'd255;
    return value[7:0];
  endfunction

  function automatic logic [31:0] predict_pixel(logic [7:0] luma, int cb, int cr);
    int y_term;
    int r_sum;
    int g_sum;
    int b_sum;
    y_term = (luma < 8'd16) ? 0 : 298 * (int'(luma) - 16);
    r_sum = (y_term + 459 * cr + 128) >>> 8;
    g_sum = (y_term - 55 * cb - 136 * cr + 128) >>> 8;
    b_sum = (y_term + 541 * cb + 128) >>> 8;
    return {8'hFF, limit_to_byte(r_sum), limit_to_byte(g_sum), limit_to_byte(b_sum)};
  endfunction

  function automatic bgra_out_t convert_pair(uyvy_in_t pair);
    bgra_out_t result;
    int cb;
    int cr;
    cb = int'(pair.cb_sample) - 128;
    cr = int'(pair.cr_sample) - 128;
    result.even_pixel    = predict_pixel(pair.luma_even, cb, cr);
    result.odd_pixel     = predict_pixel(pair.luma_odd, cb, cr);
    result.frame_end_out = pair.frame_end;
    return result;
  endfunction

  function automatic logic [7:0] pick_byte(bit edgy);
    logic [7:0] corner_values[12] = '{8'd0, 8'd1, 8'd15, 8'd16, 8'd17, 8'd127,
                                      8'd128, 8'd129, 8'd235, 8'd240, 8'd254, 8'd255};
    if (edgy) return corner_values[$urandom_range(11)];
    return 8'($urandom_range(255));
  endfunction

  function automatic uyvy_in_t random_pair();
    uyvy_in_t pair;
    bit edgy;
    edgy = ($urandom_range(9) >= 7);
    pair.cb_sample = pick_byte(edgy);
    pair.luma_even = pick_byte(edgy);
    pair.cr_sample = pick_byte(edgy);
    pair.luma_odd  = pick_byte(edgy);
    pair.frame_end = ($urandom_range(31) == 0);
    return pair;
  endfunction

  task automatic send_pair(input logic [7:0] cb, input logic [7:0] y0, input logic [7:0] cr,
                           input logic [7:0] y1, input logic fe);
    uyvy_in_t pair;
    pair = '{cb_sample: cb, luma_even: y0, cr_sample: cr, luma_odd: y1, frame_end: fe};
    while (idle_on && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= pair;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_pixels.push_back(convert_pair(pair));
  endtask

  task automatic send_random_pairs(input int count);
    uyvy_in_t pair;
    repeat (count) begin
      pair = random_pair();
      send_pair(pair.cb_sample, pair.luma_even, pair.cr_sample, pair.luma_odd, pair.frame_end);
    end
  endtask

  task automatic drain_pipe();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_pixels.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic test_luma_extremes();
    send_pair(8'd128, 8'd0, 8'd128, 8'd255, 1'b0);
    send_pair(8'd128, 8'd15, 8'd128, 8'd16, 1'b0);
    send_pair(8'd128, 8'd17, 8'd128, 8'd235, 1'b0);
    send_pair(8'd128, 8'd254, 8'd128, 8'd1, 1'b0);
  endtask

  task automatic test_chroma_saturation();
    send_pair(8'd0, 8'd16, 8'd0, 8'd235, 1'b0);
    send_pair(8'd255, 8'd16, 8'd255, 8'd235, 1'b0);
    send_pair(8'd0, 8'd255, 8'd255, 8'd0, 1'b0);
    send_pair(8'd255, 8'd255, 8'd0, 8'd16, 1'b0);
    send_pair(8'd128, 8'd128, 8'd128, 8'd128, 1'b0);
  endtask

  task automatic test_negative_rounding();
    send_pair(8'd1, 8'd16, 8'd1, 8'd17, 1'b0);
    send_pair(8'd127, 8'd16, 8'd129, 8'd16, 1'b0);
    send_pair(8'd129, 8'd16, 8'd127, 8'd16, 1'b0);
  endtask

  task automatic test_frame_end();
    send_pair(8'hAA, 8'h55, 8'h55, 8'hAA, 1'b1);
    send_pair(8'h55, 8'hAA, 8'hAA, 8'h55, 1'b0);
    send_pair(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
  endtask

  task automatic test_random_stream();
    idle_on = 1'b1;
    send_random_pairs(600);
    idle_on = 1'b0;
    send_random_pairs(350);
    idle_on = 1'b1;
    send_random_pairs(600);
  endtask

  task automatic report_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
    if (mismatch_count < 10)
      $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    out_ready <= idle_on ? ($urandom_range(99) >= IDLE_PERCENT) : 1'b1;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch("unexpected beat", 32'h0, out_data.even_pixel);
      end else begin
        want_beat = expected_pixels.pop_front();
        if (out_data.even_pixel !== want_beat.even_pixel)
          report_mismatch("even_pixel", want_beat.even_pixel, out_data.even_pixel);
        if (out_data.odd_pixel !== want_beat.odd_pixel)
          report_mismatch("odd_pixel", want_beat.odd_pixel, out_data.odd_pixel);
        if (out_data.frame_end_out !== want_beat.frame_end_out)
          report_mismatch("frame_end_out", 32'(want_beat.frame_end_out),
                          32'(out_data.frame_end_out));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_luma_extremes();
    test_chroma_saturation();
    test_negative_rounding();
    test_frame_end();
    test_random_stream();
    drain_pipe();
    if (mismatch_count == 0 && expected_pixels.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/uyvy2bgra_pkg.sv
rtl/uyvy2bgra_chroma.sv
rtl/uyvy2bgra_lane.sv
rtl/uyvy_to_bgra_color_converter.sv
verif/tb_uyvy_to_bgra_color_converter.sv
